FILE: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DWPI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define DWPI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define DWPI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define DWPI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/dwpi_pkg.sv
// types and constants of the dual wheel pi speed controller
// no dependencies
`timescale 1ns / 1ps
package dwpi_pkg;
	localparam int MUL_A_W = 36;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = 52;
	localparam int DIV_N_W = 48;
	localparam int DIV_D_W = 16;

	localparam logic [15:0] FILT_GAIN = 16'd9000;
	localparam logic [15:0] MS_PER_S  = 16'd1000;
	localparam logic [47:0] MS_HALF   = 48'd500;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [2:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_HEADING_GAIN = 3'd2,
		REG_DRIVE_LIMIT  = 3'd3,
		REG_SUPPLY       = 3'd4
	} reg_idx_t;
endpackage

FILE: hw/rtl/dwpi_mul.sv
// shift-add multiplier, signed multiplicand by unsigned multiplier, one bit per cycle
// depends on dwpi_pkg
`timescale 1ns / 1ps
module dwpi_mul
	import dwpi_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0]        b,
	output logic signed [MUL_P_W-1:0] prod,
	output unit_stat_t                stat
);
	localparam int CNT_W = $clog2(MUL_B_W + 1);

	logic signed [MUL_P_W-1:0] acc_q;
	logic signed [MUL_P_W-1:0] a_q;
	logic [MUL_B_W-1:0]        b_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MUL_B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q <= '0;
			a_q   <= MUL_P_W'(a);
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign prod      = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

FILE: hw/rtl/dwpi_div.sv
// restoring divider for unsigned operands, one quotient bit per cycle
// depends on dwpi_pkg
`timescale 1ns / 1ps
module dwpi_div
	import dwpi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] num,
	input  logic [DIV_D_W-1:0] den,
	output logic [DIV_N_W-1:0] quo,
	output unit_stat_t         stat
);
	localparam int CNT_W = $clog2(DIV_N_W + 1);

	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] den_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_D_W:0]   part;
	logic [DIV_D_W:0]   trial;

	assign part  = {rem_q, quo_q[DIV_N_W-1]};
	assign trial = part - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DIV_D_W]) begin
				rem_q <= trial[DIV_D_W-1:0];
				quo_q <= {quo_q[DIV_N_W-2:0], 1'b1};
			end else begin
				rem_q <= part[DIV_D_W-1:0];
				quo_q <= {quo_q[DIV_N_W-2:0], 1'b0};
			end
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

FILE: hw/rtl/dual_wheel_pi_speed_control_top.sv
// dual wheel pi speed controller: sequencer, wheel state, apb registers
// depends on dwpi_pkg, dwpi_mul, dwpi_div, assert_macros.svh
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata: pulses, heading, target, ms; tuser: restart
// m_axis    out  m_axis_tvalid/tready      tdata: duties, directions, counts
// apb       in   psel/penable/pready       five registers at 4*i
// a word is worked through in order: the accept, a heading multiply, then per wheel five serial
// multiplies, three serial divides and two register steps (position and error), and last the
// load of the output register
// one word at a time; a full output register with m_axis_tready low holds the result and
// keeps s_axis_tready low until it drains
// arst_n clears positions, speeds, integrals, start heading, sets both directions forward
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dual_wheel_pi_speed_control_top
	import dwpi_pkg::*;
#(
	parameter int INTEG_LIMIT = 260,
	parameter int POS_WIDTH   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// left_pulses[7:0], right_pulses[15:8], heading[32:16], target_speed[44:33],
	// elapsed_ms[54:45]
	input  logic [55:0] s_axis_tdata,
	// restart[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// left_duty[7:0], left_forward[8], right_duty[16:9], right_forward[17],
	// left_count[49:18], right_count[81:50]
	output logic [87:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int ACC_LIM_RAW = INTEG_LIMIT * 16384;
	localparam logic [23:0] ACC_LIM = (ACC_LIM_RAW > 8388607) ? 24'd8388607 :
		24'(ACC_LIM_RAW);

	typedef enum logic [3:0] {
		ST_IDLE, ST_HEAD, ST_POS, ST_SPD_A, ST_SPD_B, ST_SPD_DIV, ST_ERR,
		ST_INT_MUL, ST_INT_DIV, ST_PI_A, ST_PI_B, ST_DUTY, ST_OUT
	} state_t;

	state_t state_q;

	logic [15:0] prop_gain_q, integ_gain_q, heading_gain_q;
	logic [14:0] drive_limit_q, supply_q;

	logic signed [POS_WIDTH-1:0] pos_q [2];
	logic signed [15:0]          spd_q [2];
	logic signed [23:0]          acc_q [2];
	logic                        dir_q [2];
	logic [7:0]                  duty_q [2];
	logic signed [16:0]          start_hd_q;

	logic [7:0]         pulses_q [2];
	logic signed [16:0] hd_q;
	logic signed [11:0] target_q;
	logic [9:0]         dt_q;
	logic               w_q;
	logic               launched_q;
	logic signed [8:0]  delta_q;
	logic signed [35:0] rel_q;
	logic signed [35:0] e_q;
	logic signed [52:0] t_q;
	logic               neg_q;
	logic [47:0]        mag_q;
	logic               out_valid_q;
	logic [87:0]        out_data_q;

	logic                      mul_start, div_start;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic signed [MUL_P_W-1:0] mul_prod;
	unit_stat_t                mul_stat, div_stat;
	logic [DIV_N_W-1:0]        div_num, div_quo;
	logic [DIV_D_W-1:0]        div_den;

	logic               s_fire, cfg_wr, out_load;
	logic [2:0]         cfg_idx;
	logic [14:0]        sup_eff;
	logic signed [17:0] hd_diff;
	logic [15:0]        dt10;

	assign s_fire   = s_axis_tvalid && s_axis_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign cfg_idx  = paddr[4:2];
	assign pready   = 1'b1;
	assign sup_eff  = (supply_q == 15'd0) ? 15'd1 : supply_q;
	assign hd_diff  = 18'(hd_q) - 18'(start_hd_q);
	assign dt10     = ({6'd0, dt_q} << 3) + ({6'd0, dt_q} << 1);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// register readback
	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_PROP_GAIN:    prdata = {16'd0, prop_gain_q};
			REG_INTEG_GAIN:   prdata = {16'd0, integ_gain_q};
			REG_HEADING_GAIN: prdata = {16'd0, heading_gain_q};
			REG_DRIVE_LIMIT:  prdata = {17'd0, drive_limit_q};
			REG_SUPPLY:       prdata = {17'd0, supply_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= 16'd256;
			integ_gain_q   <= 16'd256;
			heading_gain_q <= 16'd256;
			drive_limit_q  <= 15'd12000;
			supply_q       <= 15'd12000;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PROP_GAIN:    prop_gain_q    <= pwdata[15:0];
				REG_INTEG_GAIN:   integ_gain_q   <= pwdata[15:0];
				REG_HEADING_GAIN: heading_gain_q <= pwdata[15:0];
				REG_DRIVE_LIMIT:  drive_limit_q  <= pwdata[14:0];
				REG_SUPPLY:       supply_q       <= pwdata[14:0];
				default:          ;
			endcase
		end
	end

	// shared unit operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_HEAD: begin
				mul_a = MUL_A_W'(hd_diff);
				mul_b = heading_gain_q;
			end
			ST_SPD_A: begin
				mul_a = MUL_A_W'(delta_q);
				mul_b = FILT_GAIN;
			end
			ST_SPD_B: begin
				mul_a = MUL_A_W'(spd_q[w_q]);
				mul_b = {6'd0, dt_q};
			end
			ST_INT_MUL: begin
				mul_a = e_q;
				mul_b = {6'd0, dt_q};
			end
			ST_PI_A: begin
				mul_a = e_q;
				mul_b = prop_gain_q;
			end
			ST_PI_B: begin
				mul_a = MUL_A_W'(acc_q[w_q]);
				mul_b = integ_gain_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		div_den = '0;
		case (state_q)
			ST_SPD_DIV: div_den = dt10;
			ST_INT_DIV: div_den = MS_PER_S;
			ST_DUTY:    div_den = {1'b0, sup_eff};
			default:    div_den = '0;
		endcase
	end

	assign div_num   = mag_q;
	assign mul_start = !launched_q && (state_q inside {ST_HEAD, ST_SPD_A, ST_SPD_B,
		ST_INT_MUL, ST_PI_A, ST_PI_B});
	assign div_start = !launched_q && (state_q inside {ST_SPD_DIV, ST_INT_DIV, ST_DUTY});

	dwpi_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.prod  (mul_prod),
		.stat  (mul_stat)
	);

	dwpi_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.quo   (div_quo),
		.stat  (div_stat)
	);

	// step results
	logic signed [52:0] sum_spd;
	logic signed [15:0] spd_new;
	logic signed [17:0] spd_err;
	logic signed [35:0] e_new;
	logic signed [52:0] iprod_abs;
	logic signed [49:0] istep, acc_sum;
	logic signed [23:0] acc_new;
	logic signed [52:0] p_sum, p_lim, p_clamp;
	logic [47:0]        p_mag, duty_num;

	always_comb begin
		sum_spd = t_q + 53'(mul_prod);
		if (!neg_q) begin
			spd_new = (div_quo > 48'd32767) ? 16'sd32767 : div_quo[15:0];
		end else begin
			spd_new = (div_quo > 48'd32768) ? -16'sd32768 : 16'(-div_quo[15:0]);
		end
		spd_err = 18'(target_q) - 18'(spd_q[w_q]);
		e_new   = (36'(spd_err) <<< 14) + (w_q ? rel_q : -rel_q);

		iprod_abs = (mul_prod < 0) ? -53'(mul_prod) : 53'(mul_prod);
		istep     = neg_q ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
		acc_sum   = 50'(acc_q[w_q]) + istep;
		if (acc_sum > $signed({26'd0, ACC_LIM})) begin
			acc_new = $signed(ACC_LIM);
		end else if (acc_sum < -$signed({26'd0, ACC_LIM})) begin
			acc_new = -$signed(ACC_LIM);
		end else begin
			acc_new = acc_sum[23:0];
		end

		p_sum = t_q + 53'(mul_prod);
		p_lim = $signed({16'd0, drive_limit_q, 22'd0});
		if (p_sum > p_lim) begin
			p_clamp = p_lim;
		end else if (p_sum < -p_lim) begin
			p_clamp = -p_lim;
		end else begin
			p_clamp = p_sum;
		end
		p_mag    = (p_clamp < 0) ? 48'(-p_clamp) : 48'(p_clamp);
		duty_num = (p_mag << 8) - p_mag + ({33'd0, sup_eff} << 21);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launched_q  <= 1'b0;
			out_valid_q <= 1'b0;
			w_q         <= 1'b0;
			start_hd_q  <= '0;
			for (int i = 0; i < 2; i++) begin
				pos_q[i] <= '0;
				spd_q[i] <= '0;
				acc_q[i] <= '0;
				dir_q[i] <= 1'b1;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (mul_start || div_start) begin
				launched_q <= 1'b1;
			end else if (mul_stat.done || div_stat.done) begin
				launched_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						w_q     <= 1'b0;
						state_q <= ST_HEAD;
						if (s_axis_tuser) begin
							start_hd_q <= s_axis_tdata[32:16];
							for (int i = 0; i < 2; i++) begin
								pos_q[i] <= '0;
								spd_q[i] <= '0;
								acc_q[i] <= '0;
							end
						end
					end
				end
				ST_HEAD: begin
					if (mul_stat.done) begin
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					pos_q[w_q] <= pos_q[w_q] + POS_WIDTH'(dir_q[w_q] ?
						$signed({1'b0, pulses_q[w_q]}) : -$signed({1'b0, pulses_q[w_q]}));
					state_q <= ST_SPD_A;
				end
				ST_SPD_A: begin
					if (mul_stat.done) begin
						state_q <= ST_SPD_B;
					end
				end
				ST_SPD_B: begin
					if (mul_stat.done) begin
						state_q <= ST_SPD_DIV;
					end
				end
				ST_SPD_DIV: begin
					if (div_stat.done) begin
						spd_q[w_q] <= spd_new;
						state_q    <= ST_ERR;
					end
				end
				ST_ERR: begin
					state_q <= ST_INT_MUL;
				end
				ST_INT_MUL: begin
					if (mul_stat.done) begin
						state_q <= ST_INT_DIV;
					end
				end
				ST_INT_DIV: begin
					if (div_stat.done) begin
						acc_q[w_q] <= acc_new;
						state_q    <= ST_PI_A;
					end
				end
				ST_PI_A: begin
					if (mul_stat.done) begin
						state_q <= ST_PI_B;
					end
				end
				ST_PI_B: begin
					if (mul_stat.done) begin
						dir_q[w_q] <= (p_clamp >= 0);
						state_q    <= ST_DUTY;
					end
				end
				ST_DUTY: begin
					if (div_stat.done) begin
						if (w_q == 1'b0) begin
							w_q     <= 1'b1;
							state_q <= ST_POS;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			pulses_q[0] <= s_axis_tdata[7:0];
			pulses_q[1] <= s_axis_tdata[15:8];
			hd_q        <= s_axis_tdata[32:16];
			target_q    <= s_axis_tdata[44:33];
			dt_q        <= (s_axis_tdata[54:45] == 10'd0) ? 10'd1 : s_axis_tdata[54:45];
		end
		case (state_q)
			ST_HEAD: begin
				if (mul_stat.done) begin
					rel_q <= mul_prod[35:0];
				end
			end
			ST_POS: begin
				delta_q <= dir_q[w_q] ? $signed({1'b0, pulses_q[w_q]}) :
					-$signed({1'b0, pulses_q[w_q]});
			end
			ST_SPD_A: begin
				if (mul_stat.done) begin
					t_q <= 53'(mul_prod);
				end
			end
			ST_SPD_B: begin
				if (mul_stat.done) begin
					neg_q <= sum_spd[52];
					mag_q <= sum_spd[52] ? 48'(-sum_spd) : 48'(sum_spd);
				end
			end
			ST_ERR: begin
				e_q <= e_new;
			end
			ST_INT_MUL: begin
				if (mul_stat.done) begin
					neg_q <= mul_prod[MUL_P_W-1];
					mag_q <= 48'(iprod_abs) + MS_HALF;
				end
			end
			ST_PI_A: begin
				if (mul_stat.done) begin
					t_q <= 53'(mul_prod);
				end
			end
			ST_PI_B: begin
				if (mul_stat.done) begin
					mag_q <= {22'd0, duty_num[47:22]};
				end
			end
			ST_DUTY: begin
				if (div_stat.done) begin
					duty_q[w_q] <= (div_quo > 48'd255) ? 8'd255 : div_quo[7:0];
				end
			end
			ST_OUT: begin
				if (out_load) begin
					out_data_q <= {6'd0, 32'($signed(pos_q[1])), 32'($signed(pos_q[0])),
						dir_q[1], duty_q[1], dir_q[0], duty_q[0]};
				end
			end
			default: ;
		endcase
	end

	`DWPI_ASSERT_IMP(a_units_idle, clk, arst_n, s_axis_tready, !mul_stat.busy && !div_stat.busy, "unit busy while idle")
	`DWPI_ASSERT_IMP(a_one_unit, clk, arst_n, 1'b1, !(mul_stat.busy && div_stat.busy), "both units busy")
	`DWPI_ASSERT_NXT(a_take_busy, clk, arst_n, s_fire, !s_axis_tready, "second word taken during work")
endmodule
